// File: hw/rtl/jps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jps_pkg
// Types, kind codes, prefix states and match tables of the punctuator scanner.
// ----------------------------------------------------------------------------
package jps_pkg;

	typedef logic [5:0] kind_t;
	typedef logic [4:0] pstate_t;
	typedef logic [2:0] tlen_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_marker;
		logic       regex_allowed;
	} in_t;

	typedef struct packed {
		kind_t token_kind;
		tlen_t token_length;
		logic  last_of_run;
	} out_t;

	typedef struct packed {
		kind_t kind;
		tlen_t len;
	} tok_t;

	// results caused by one byte, in order
	typedef struct packed {
		logic [1:0]   cnt;
		tok_t [2:0]   tok;
	} bundle_t;

	typedef struct packed {
		pstate_t prefix;
		logic    slash_flag;
	} scan_state_t;

	typedef struct packed {
		logic  hit;
		logic  done;
		kind_t to;
	} step_edge_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// token kinds
	localparam kind_t K_LPAREN    = 6'd0;
	localparam kind_t K_RPAREN    = 6'd1;
	localparam kind_t K_LBRACE    = 6'd2;
	localparam kind_t K_RBRACE    = 6'd3;
	localparam kind_t K_LBRACKET  = 6'd4;
	localparam kind_t K_RBRACKET  = 6'd5;
	localparam kind_t K_SEMI      = 6'd6;
	localparam kind_t K_COMMA     = 6'd7;
	localparam kind_t K_COLON     = 6'd8;
	localparam kind_t K_TILDE     = 6'd9;
	localparam kind_t K_HASH      = 6'd10;
	localparam kind_t K_PLUS      = 6'd11;
	localparam kind_t K_INC       = 6'd12;
	localparam kind_t K_PLUS_EQ   = 6'd13;
	localparam kind_t K_MINUS     = 6'd14;
	localparam kind_t K_DEC       = 6'd15;
	localparam kind_t K_MINUS_EQ  = 6'd16;
	localparam kind_t K_STAR      = 6'd17;
	localparam kind_t K_EXP       = 6'd18;
	localparam kind_t K_EXP_EQ    = 6'd19;
	localparam kind_t K_STAR_EQ   = 6'd20;
	localparam kind_t K_SLASH     = 6'd21;
	localparam kind_t K_SLASH_EQ  = 6'd22;
	localparam kind_t K_PCT       = 6'd23;
	localparam kind_t K_PCT_EQ    = 6'd24;
	localparam kind_t K_ASSIGN    = 6'd25;
	localparam kind_t K_EQ        = 6'd26;
	localparam kind_t K_STRICT_EQ = 6'd27;
	localparam kind_t K_ARROW     = 6'd28;
	localparam kind_t K_BANG      = 6'd29;
	localparam kind_t K_NE        = 6'd30;
	localparam kind_t K_STRICT_NE = 6'd31;
	localparam kind_t K_LT        = 6'd32;
	localparam kind_t K_LE        = 6'd33;
	localparam kind_t K_SHL       = 6'd34;
	localparam kind_t K_SHL_EQ    = 6'd35;
	localparam kind_t K_GT        = 6'd36;
	localparam kind_t K_GE        = 6'd37;
	localparam kind_t K_SHR       = 6'd38;
	localparam kind_t K_USHR      = 6'd39;
	localparam kind_t K_USHR_EQ   = 6'd40;
	localparam kind_t K_SHR_EQ    = 6'd41;
	localparam kind_t K_AMP       = 6'd42;
	localparam kind_t K_AND       = 6'd43;
	localparam kind_t K_AND_EQ    = 6'd44;
	localparam kind_t K_AMP_EQ    = 6'd45;
	localparam kind_t K_PIPE      = 6'd46;
	localparam kind_t K_OR        = 6'd47;
	localparam kind_t K_OR_EQ     = 6'd48;
	localparam kind_t K_PIPE_EQ   = 6'd49;
	localparam kind_t K_CARET     = 6'd50;
	localparam kind_t K_CARET_EQ  = 6'd51;
	localparam kind_t K_DOT       = 6'd52;
	localparam kind_t K_ELLIPSIS  = 6'd53;
	localparam kind_t K_QUEST     = 6'd54;
	localparam kind_t K_OPT_CHAIN = 6'd55;
	localparam kind_t K_NULLISH   = 6'd56;
	localparam kind_t K_NULL_EQ   = 6'd57;
	localparam kind_t K_LINECMT   = 6'd58;
	localparam kind_t K_BLOCKCMT  = 6'd59;
	localparam kind_t K_REGEX     = 6'd60;
	localparam kind_t K_OTHER     = 6'd61;

	// pending prefix states
	localparam pstate_t ST_IDLE    = 5'd0;
	localparam pstate_t ST_PLUS    = 5'd1;
	localparam pstate_t ST_MINUS   = 5'd2;
	localparam pstate_t ST_STAR    = 5'd3;
	localparam pstate_t ST_STAR2   = 5'd4;
	localparam pstate_t ST_SLASH   = 5'd5;
	localparam pstate_t ST_PCT     = 5'd6;
	localparam pstate_t ST_EQ      = 5'd7;
	localparam pstate_t ST_EQ2     = 5'd8;
	localparam pstate_t ST_BANG    = 5'd9;
	localparam pstate_t ST_BANG_EQ = 5'd10;
	localparam pstate_t ST_LT      = 5'd11;
	localparam pstate_t ST_LT2     = 5'd12;
	localparam pstate_t ST_GT      = 5'd13;
	localparam pstate_t ST_GT2     = 5'd14;
	localparam pstate_t ST_GT3     = 5'd15;
	localparam pstate_t ST_AMP     = 5'd16;
	localparam pstate_t ST_AMP2    = 5'd17;
	localparam pstate_t ST_PIPE    = 5'd18;
	localparam pstate_t ST_PIPE2   = 5'd19;
	localparam pstate_t ST_CARET   = 5'd20;
	localparam pstate_t ST_DOT     = 5'd21;
	localparam pstate_t ST_DOT2    = 5'd22;
	localparam pstate_t ST_QUEST   = 5'd23;
	localparam pstate_t ST_QUEST2  = 5'd24;
	localparam pstate_t ST_COUNT   = 5'd25;

	function automatic step_edge_t go_state(input pstate_t s);
		step_edge_t r;
		r.hit  = 1'b1;
		r.done = 1'b0;
		r.to   = {1'b0, s};
		return r;
	endfunction

	function automatic step_edge_t go_kind(input kind_t k);
		step_edge_t r;
		r.hit  = 1'b1;
		r.done = 1'b1;
		r.to   = k;
		return r;
	endfunction

	// transition of a pending prefix on one byte
	function automatic step_edge_t next_edge(input pstate_t s, input logic [7:0] c);
		step_edge_t r;
		r = '0;
		case (s)
			ST_IDLE: begin
				case (c)
					"+":     r = go_state(ST_PLUS);
					"-":     r = go_state(ST_MINUS);
					"*":     r = go_state(ST_STAR);
					"/":     r = go_state(ST_SLASH);
					"%":     r = go_state(ST_PCT);
					"=":     r = go_state(ST_EQ);
					"!":     r = go_state(ST_BANG);
					"<":     r = go_state(ST_LT);
					">":     r = go_state(ST_GT);
					"&":     r = go_state(ST_AMP);
					"|":     r = go_state(ST_PIPE);
					"^":     r = go_state(ST_CARET);
					".":     r = go_state(ST_DOT);
					"?":     r = go_state(ST_QUEST);
					default: r = '0;
				endcase
			end
			ST_PLUS: begin
				if (c == "+") r = go_kind(K_INC);
				else if (c == "=") r = go_kind(K_PLUS_EQ);
			end
			ST_MINUS: begin
				if (c == "-") r = go_kind(K_DEC);
				else if (c == "=") r = go_kind(K_MINUS_EQ);
			end
			ST_STAR: begin
				if (c == "*") r = go_state(ST_STAR2);
				else if (c == "=") r = go_kind(K_STAR_EQ);
			end
			ST_STAR2: begin
				if (c == "=") r = go_kind(K_EXP_EQ);
			end
			ST_SLASH: begin
				if (c == "/") r = go_kind(K_LINECMT);
				else if (c == "*") r = go_kind(K_BLOCKCMT);
				else if (c == "=") r = go_kind(K_SLASH_EQ);
			end
			ST_PCT: begin
				if (c == "=") r = go_kind(K_PCT_EQ);
			end
			ST_EQ: begin
				if (c == "=") r = go_state(ST_EQ2);
				else if (c == ">") r = go_kind(K_ARROW);
			end
			ST_EQ2: begin
				if (c == "=") r = go_kind(K_STRICT_EQ);
			end
			ST_BANG: begin
				if (c == "=") r = go_state(ST_BANG_EQ);
			end
			ST_BANG_EQ: begin
				if (c == "=") r = go_kind(K_STRICT_NE);
			end
			ST_LT: begin
				if (c == "=") r = go_kind(K_LE);
				else if (c == "<") r = go_state(ST_LT2);
			end
			ST_LT2: begin
				if (c == "=") r = go_kind(K_SHL_EQ);
			end
			ST_GT: begin
				if (c == "=") r = go_kind(K_GE);
				else if (c == ">") r = go_state(ST_GT2);
			end
			ST_GT2: begin
				if (c == ">") r = go_state(ST_GT3);
				else if (c == "=") r = go_kind(K_SHR_EQ);
			end
			ST_GT3: begin
				if (c == "=") r = go_kind(K_USHR_EQ);
			end
			ST_AMP: begin
				if (c == "&") r = go_state(ST_AMP2);
				else if (c == "=") r = go_kind(K_AMP_EQ);
			end
			ST_AMP2: begin
				if (c == "=") r = go_kind(K_AND_EQ);
			end
			ST_PIPE: begin
				if (c == "|") r = go_state(ST_PIPE2);
				else if (c == "=") r = go_kind(K_PIPE_EQ);
			end
			ST_PIPE2: begin
				if (c == "=") r = go_kind(K_OR_EQ);
			end
			ST_CARET: begin
				if (c == "=") r = go_kind(K_CARET_EQ);
			end
			ST_DOT: begin
				if (c == ".") r = go_state(ST_DOT2);
			end
			ST_DOT2: begin
				if (c == ".") r = go_kind(K_ELLIPSIS);
			end
			ST_QUEST: begin
				if (c == ".") r = go_kind(K_OPT_CHAIN);
				else if (c == "?") r = go_state(ST_QUEST2);
			end
			ST_QUEST2: begin
				if (c == "=") r = go_kind(K_NULL_EQ);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// kind of a pending prefix emitted on its own
	function automatic kind_t flush_kind(input pstate_t s);
		kind_t k;
		case (s)
			ST_PLUS:    k = K_PLUS;
			ST_MINUS:   k = K_MINUS;
			ST_STAR:    k = K_STAR;
			ST_STAR2:   k = K_EXP;
			ST_SLASH:   k = K_SLASH;
			ST_PCT:     k = K_PCT;
			ST_EQ:      k = K_ASSIGN;
			ST_EQ2:     k = K_EQ;
			ST_BANG:    k = K_BANG;
			ST_BANG_EQ: k = K_NE;
			ST_LT:      k = K_LT;
			ST_LT2:     k = K_SHL;
			ST_GT:      k = K_GT;
			ST_GT2:     k = K_SHR;
			ST_GT3:     k = K_USHR;
			ST_AMP:     k = K_AMP;
			ST_AMP2:    k = K_AND;
			ST_PIPE:    k = K_PIPE;
			ST_PIPE2:   k = K_OR;
			ST_CARET:   k = K_CARET;
			ST_DOT:     k = K_DOT;
			ST_DOT2:    k = K_DOT;
			ST_QUEST:   k = K_QUEST;
			ST_QUEST2:  k = K_NULLISH;
			default:    k = K_OTHER;
		endcase
		return k;
	endfunction

	function automatic tlen_t prefix_len(input pstate_t s);
		tlen_t l;
		case (s)
			ST_STAR2, ST_EQ2, ST_BANG_EQ, ST_LT2, ST_GT2, ST_AMP2, ST_PIPE2,
			ST_DOT2, ST_QUEST2: l = 3'd2;
			ST_GT3:             l = 3'd3;
			ST_IDLE:            l = 3'd0;
			default:            l = 3'd1;
		endcase
		return l;
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"[":     k = K_LBRACKET;
			"]":     k = K_RBRACKET;
			";":     k = K_SEMI;
			",":     k = K_COMMA;
			":":     k = K_COLON;
			"~":     k = K_TILDE;
			"#":     k = K_HASH;
			default: k = K_OTHER;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/jps_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jps_scan
// Next prefix state and the ordered results caused by one input byte.
// ----------------------------------------------------------------------------
module jps_scan (
	input  wire jps_pkg::in_t         item,
	input  wire jps_pkg::scan_state_t cur,
	output jps_pkg::scan_state_t      nxt,
	output jps_pkg::bundle_t          bundle
);

	jps_pkg::step_edge_t e_cur;
	jps_pkg::step_edge_t e_fresh;
	logic                idle;
	logic                slash_body;
	logic                do_flush;
	logic                do_fresh;
	logic [1:0]          n;

	assign e_cur   = jps_pkg::next_edge(cur.prefix, item.byte_value);
	assign e_fresh = jps_pkg::next_edge(jps_pkg::ST_IDLE, item.byte_value);
	assign idle    = (cur.prefix == jps_pkg::ST_IDLE) || (cur.prefix >= jps_pkg::ST_COUNT);
	assign slash_body = (cur.prefix == jps_pkg::ST_SLASH) && cur.slash_flag &&
		(item.byte_value != "/") && (item.byte_value != "*");

	always_comb begin
		nxt        = cur;
		bundle     = '0;
		n          = 2'd0;
		do_flush   = 1'b0;
		do_fresh   = 1'b0;

		if (item.end_marker) begin
			do_flush   = 1'b1;
			nxt.prefix = jps_pkg::ST_IDLE;
		end else if (idle) begin
			do_fresh = 1'b1;
		end else if (e_cur.hit && !slash_body) begin
			if (e_cur.done) begin
				bundle.tok[n].kind = e_cur.to;
				bundle.tok[n].len  = jps_pkg::prefix_len(cur.prefix) + 3'd1;
				n          = n + 2'd1;
				nxt.prefix = jps_pkg::ST_IDLE;
			end else begin
				nxt.prefix = e_cur.to[4:0];
			end
		end else begin
			do_flush = 1'b1;
			do_fresh = 1'b1;
		end

		// emit the pending prefix
		if (do_flush && !idle) begin
			nxt.prefix = jps_pkg::ST_IDLE;
			if (cur.prefix == jps_pkg::ST_SLASH) begin
				bundle.tok[n].kind = cur.slash_flag ? jps_pkg::K_REGEX : jps_pkg::K_SLASH;
				bundle.tok[n].len  = 3'd1;
				n = n + 2'd1;
			end else if (cur.prefix == jps_pkg::ST_DOT2) begin
				bundle.tok[n].kind = jps_pkg::K_DOT;
				bundle.tok[n].len  = 3'd1;
				n = n + 2'd1;
				bundle.tok[n].kind = jps_pkg::K_DOT;
				bundle.tok[n].len  = 3'd1;
				n = n + 2'd1;
			end else begin
				bundle.tok[n].kind = jps_pkg::flush_kind(cur.prefix);
				bundle.tok[n].len  = jps_pkg::prefix_len(cur.prefix);
				n = n + 2'd1;
			end
		end

		// scan the byte with no prefix pending
		if (do_fresh) begin
			if (e_fresh.hit) begin
				nxt.prefix = e_fresh.to[4:0];
				if (e_fresh.to[4:0] == jps_pkg::ST_SLASH) begin
					nxt.slash_flag = item.regex_allowed;
				end
			end else begin
				nxt.prefix = jps_pkg::ST_IDLE;
				bundle.tok[n].kind = jps_pkg::single_kind(item.byte_value);
				bundle.tok[n].len  = 3'd1;
				n = n + 2'd1;
			end
		end

		bundle.cnt = n;
	end

endmodule
`default_nettype wire

// File: hw/rtl/jps_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jps_result_fifo
// Queue of per-byte result groups, drained one token per transfer.
// ----------------------------------------------------------------------------
module jps_result_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire jps_pkg::bundle_t push_data,
	output logic                  room,
	output logic                  tok_valid,
	input  wire                   tok_stall,
	output jps_pkg::out_t         tok_item
);

	jps_pkg::bundle_t                mem_q [jps_pkg::FIFO_DEPTH];
	logic [jps_pkg::FIFO_AW-1:0]     wptr_q;
	logic [jps_pkg::FIFO_AW-1:0]     rptr_q;
	logic [jps_pkg::FIFO_CW-1:0]     count_q;
	logic [1:0]                      sub_q;
	jps_pkg::bundle_t                head;
	logic                            last;
	logic                            xfer;
	logic                            pop;

	assign head      = mem_q[rptr_q];
	assign last      = (sub_q == (head.cnt - 2'd1));
	assign tok_valid = (count_q != '0);
	assign xfer      = tok_valid && !tok_stall;
	assign pop       = xfer && last;
	assign room      = (count_q != jps_pkg::FIFO_CW'(jps_pkg::FIFO_DEPTH));

	assign tok_item.token_kind   = head.tok[sub_q].kind;
	assign tok_item.token_length = head.tok[sub_q].len;
	assign tok_item.last_of_run  = last;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			sub_q   <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + jps_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + jps_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + jps_pkg::FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - jps_pkg::FIFO_CW'(1);
			end
			if (xfer) begin
				sub_q <= last ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/js_punctuator_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// js_punctuator_scanner_core
// Longest-match JavaScript punctuator scanner, one source byte per transfer.
//
//   channel  valid       stall       payload
//   bytes    byte_valid  byte_stall  byte_item (jps_pkg::in_t)
//   tokens   tok_valid   tok_stall   tok_item  (jps_pkg::out_t)
//
// a byte is scanned in the input register; its zero to three tokens land in
// a four-entry result queue, the first offered the cycle after that if the
// queue was empty. one byte per cycle is taken while the queue has room; the
// queue drains one token per cycle without tok_stall, so bytes that give two
// or three tokens set the rate. reset leaves no prefix pending and the queue
// empty. byte_stall rises only when a scanned byte waits on a full queue.
// ----------------------------------------------------------------------------
module js_punctuator_scanner_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                byte_valid,
	output logic               byte_stall,
	input  wire jps_pkg::in_t  byte_item,
	output logic               tok_valid,
	input  wire                tok_stall,
	output jps_pkg::out_t      tok_item
);

	jps_pkg::in_t        item_s1;
	logic                valid_s1;
	jps_pkg::scan_state_t state_q;
	jps_pkg::scan_state_t state_nxt;
	jps_pkg::bundle_t    bundle;
	logic                room;
	logic                accept;
	logic                process;

	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;
	assign process    = valid_s1 && room;

	jps_scan u_scan (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.bundle (bundle)
	);

	jps_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (process && (bundle.cnt != 2'd0)),
		.push_data (bundle),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end
			if (process) begin
				state_q <= state_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// File: dv/tb_js_punctuator_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_js_punctuator_scanner_core
// Self-checking bench for the punctuator scanner: a token tracker predicts
// the tokens of each accepted byte and compares every token transfer in
// order, under random idle bursts on the byte side and stall bursts on the
// token side.
// ----------------------------------------------------------------------------
module tb_js_punctuator_scanner_core;
	import jps_pkg::*;

	localparam logic [6:0] NO_ARC = 7'h7F;

	class token_tracker;
		out_t    expected_tokens[$];
		out_t    run_tokens[$];
		pstate_t prefix;
		logic    slash_flag;
		int      mismatch_count;
		kind_t   lone_kind[25];
		tlen_t   lone_len[25];
		logic [7:0] single_chars[11];

		function new();
			prefix = ST_IDLE;
			slash_flag = 1'b0;
			mismatch_count = 0;
			lone_kind = '{K_OTHER, K_PLUS, K_MINUS, K_STAR, K_EXP, K_SLASH, K_PCT,
				K_ASSIGN, K_EQ, K_BANG, K_NE, K_LT, K_SHL, K_GT, K_SHR, K_USHR,
				K_AMP, K_AND, K_PIPE, K_OR, K_CARET, K_DOT, K_DOT, K_QUEST,
				K_NULLISH};
			lone_len = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2,
				3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd1, 3'd2,
				3'd1, 3'd1, 3'd2, 3'd1, 3'd2};
			single_chars = '{"(", ")", "{", "}", "[", "]", ";", ",", ":", "~", "#"};
		endfunction

		// {done, kind} or {0, 0, next prefix}
		function logic [6:0] arc_of(input pstate_t s, input logic [7:0] c);
			logic [6:0] r;
			case ({s, c})
				{ST_IDLE, "+"}:     r = {2'b00, ST_PLUS};
				{ST_IDLE, "-"}:     r = {2'b00, ST_MINUS};
				{ST_IDLE, "*"}:     r = {2'b00, ST_STAR};
				{ST_IDLE, "/"}:     r = {2'b00, ST_SLASH};
				{ST_IDLE, "%"}:     r = {2'b00, ST_PCT};
				{ST_IDLE, "="}:     r = {2'b00, ST_EQ};
				{ST_IDLE, "!"}:     r = {2'b00, ST_BANG};
				{ST_IDLE, "<"}:     r = {2'b00, ST_LT};
				{ST_IDLE, ">"}:     r = {2'b00, ST_GT};
				{ST_IDLE, "&"}:     r = {2'b00, ST_AMP};
				{ST_IDLE, "|"}:     r = {2'b00, ST_PIPE};
				{ST_IDLE, "^"}:     r = {2'b00, ST_CARET};
				{ST_IDLE, "."}:     r = {2'b00, ST_DOT};
				{ST_IDLE, "?"}:     r = {2'b00, ST_QUEST};
				{ST_PLUS, "+"}:     r = {1'b1, K_INC};
				{ST_PLUS, "="}:     r = {1'b1, K_PLUS_EQ};
				{ST_MINUS, "-"}:    r = {1'b1, K_DEC};
				{ST_MINUS, "="}:    r = {1'b1, K_MINUS_EQ};
				{ST_STAR, "*"}:     r = {2'b00, ST_STAR2};
				{ST_STAR, "="}:     r = {1'b1, K_STAR_EQ};
				{ST_STAR2, "="}:    r = {1'b1, K_EXP_EQ};
				{ST_SLASH, "/"}:    r = {1'b1, K_LINECMT};
				{ST_SLASH, "*"}:    r = {1'b1, K_BLOCKCMT};
				{ST_SLASH, "="}:    r = {1'b1, K_SLASH_EQ};
				{ST_PCT, "="}:      r = {1'b1, K_PCT_EQ};
				{ST_EQ, "="}:       r = {2'b00, ST_EQ2};
				{ST_EQ, ">"}:       r = {1'b1, K_ARROW};
				{ST_EQ2, "="}:      r = {1'b1, K_STRICT_EQ};
				{ST_BANG, "="}:     r = {2'b00, ST_BANG_EQ};
				{ST_BANG_EQ, "="}:  r = {1'b1, K_STRICT_NE};
				{ST_LT, "="}:       r = {1'b1, K_LE};
				{ST_LT, "<"}:       r = {2'b00, ST_LT2};
				{ST_LT2, "="}:      r = {1'b1, K_SHL_EQ};
				{ST_GT, "="}:       r = {1'b1, K_GE};
				{ST_GT, ">"}:       r = {2'b00, ST_GT2};
				{ST_GT2, ">"}:      r = {2'b00, ST_GT3};
				{ST_GT2, "="}:      r = {1'b1, K_SHR_EQ};
				{ST_GT3, "="}:      r = {1'b1, K_USHR_EQ};
				{ST_AMP, "&"}:      r = {2'b00, ST_AMP2};
				{ST_AMP, "="}:      r = {1'b1, K_AMP_EQ};
				{ST_AMP2, "="}:     r = {1'b1, K_AND_EQ};
				{ST_PIPE, "|"}:     r = {2'b00, ST_PIPE2};
				{ST_PIPE, "="}:     r = {1'b1, K_PIPE_EQ};
				{ST_PIPE2, "="}:    r = {1'b1, K_OR_EQ};
				{ST_CARET, "="}:    r = {1'b1, K_CARET_EQ};
				{ST_DOT, "."}:      r = {2'b00, ST_DOT2};
				{ST_DOT2, "."}:     r = {1'b1, K_ELLIPSIS};
				{ST_QUEST, "."}:    r = {1'b1, K_OPT_CHAIN};
				{ST_QUEST, "?"}:    r = {2'b00, ST_QUEST2};
				{ST_QUEST2, "="}:   r = {1'b1, K_NULL_EQ};
				default:            r = NO_ARC;
			endcase
			return r;
		endfunction

		function void push_token(input kind_t k, input tlen_t l);
			out_t t;
			t.token_kind = k;
			t.token_length = l;
			t.last_of_run = 1'b0;
			run_tokens = {run_tokens, t};
		endfunction

		function void flush_prefix();
			pstate_t s;
			s = prefix;
			prefix = ST_IDLE;
			if (s == ST_IDLE || s >= ST_COUNT)
				return;
			if (s == ST_SLASH) begin
				push_token(slash_flag ? K_REGEX : K_SLASH, 3'd1);
			end else if (s == ST_DOT2) begin
				push_token(K_DOT, 3'd1);
				push_token(K_DOT, 3'd1);
			end else begin
				push_token(lone_kind[s], lone_len[s]);
			end
		endfunction

		function void scan_fresh(input logic [7:0] c, input logic flag);
			logic [6:0] a;
			a = arc_of(ST_IDLE, c);
			if (a != NO_ARC) begin
				prefix = a[4:0];
				if (prefix == ST_SLASH)
					slash_flag = flag;
				return;
			end
			for (int i = 0; i < 11; i++) begin
				if (single_chars[i] == c) begin
					push_token(kind_t'(i), 3'd1);
					return;
				end
			end
			push_token(K_OTHER, 3'd1);
		endfunction

		function void note_byte(input in_t it);
			logic [6:0] a;
			logic       slash_body;
			run_tokens.delete();
			if (it.end_marker) begin
				flush_prefix();
			end else if (prefix == ST_IDLE || prefix >= ST_COUNT) begin
				prefix = ST_IDLE;
				scan_fresh(it.byte_value, it.regex_allowed);
			end else begin
				a = arc_of(prefix, it.byte_value);
				slash_body = prefix == ST_SLASH && slash_flag &&
					it.byte_value != "/" && it.byte_value != "*";
				if (a != NO_ARC && !slash_body) begin
					if (a[6]) begin
						push_token(a[5:0], lone_len[prefix] + 3'd1);
						prefix = ST_IDLE;
					end else begin
						prefix = a[4:0];
					end
				end else begin
					flush_prefix();
					scan_fresh(it.byte_value, it.regex_allowed);
				end
			end
			if (run_tokens.size() > 0)
				run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
			expected_tokens = {expected_tokens, run_tokens};
		endfunction

		function void check_token(input out_t got);
			out_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token kind %0d len %0d last %0b", $time,
					got.token_kind, got.token_length, got.last_of_run);
				mismatch_count++;
				return;
			end
			want = expected_tokens.pop_front();
			if (got.token_kind !== want.token_kind) begin
				$display("%0t: token_kind expected %0d actual %0d", $time,
					want.token_kind, got.token_kind);
				mismatch_count++;
			end
			if (got.token_length !== want.token_length) begin
				$display("%0t: token_length expected %0d actual %0d", $time,
					want.token_length, got.token_length);
				mismatch_count++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$display("%0t: last_of_run expected %0b actual %0b", $time,
					want.last_of_run, got.last_of_run);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_t  byte_item = '0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	out_t tok_item;

	token_tracker tracker = new();
	bit quiet = 1'b0;
	int bytes_sent = 0;

	js_punctuator_scanner_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_item   (tok_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("js_punctuator_scanner_core: mismatch");
		$finish;
	end

	function automatic in_t mk(input logic [7:0] c, input logic endm, input logic flag);
		in_t it;
		it.byte_value = c;
		it.end_marker = endm;
		it.regex_allowed = flag;
		return it;
	endfunction

	task automatic send_byte(input in_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		tracker.note_byte(it);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic flag);
		for (int i = 0; i < s.len(); i++)
			send_byte(mk(s[i], 1'b0, flag));
	endtask

	// token side: stall bursts and checking of each transfer
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && tok_valid && !tok_stall)
				tracker.check_token(tok_item);
			if (stall_left > 0) begin
				stall_left--;
				tok_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = int'($urandom_range(1, 17)) - 1;
				tok_stall <= 1'b1;
			end else begin
				tok_stall <= 1'b0;
			end
		end
	end

	initial begin
		string punct[$];
		string pick;
		int    choice;
		punct = '{"+", "++", "+=", "-", "--", "-=", "*", "**", "**=", "*=", "/", "//",
			"/*", "/=", "%", "%=", "=", "==", "===", "=>", "!", "!=", "!==", "<",
			"<=", "<<", "<<=", ">", ">=", ">>", ">>>", ">>>=", ">>=", "&", "&&",
			"&&=", "&=", "|", "||", "||=", "|=", "^", "^=", ".", "..", "...", "?",
			"?.", "??", "??=", "(", ")", "{", "}", "[", "]", ";", ",", ":", "~",
			"#", ".5", "a", " "};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of the byte, end marker while idle and pending
		send_byte(mk(8'h00, 1'b0, 1'b0));
		send_byte(mk(8'hFF, 1'b0, 1'b1));
		send_byte(mk(8'hA5, 1'b1, 1'b0));
		send_text(">>>=", 1'b0);
		send_text("..x", 1'b1);
		send_byte(mk("/", 1'b0, 1'b1));
		send_byte(mk("=", 1'b0, 1'b0));
		send_byte(mk("/", 1'b0, 1'b0));
		send_byte(mk("/", 1'b0, 1'b1));
		send_byte(mk("/", 1'b0, 1'b1));
		send_byte(mk("*", 1'b0, 1'b0));
		send_text(".5", 1'b0);
		send_text("??", 1'b0);
		send_byte(mk(8'hFF, 1'b1, 1'b1));
		send_text("..", 1'b0);
		send_byte(mk(8'h00, 1'b1, 1'b0));
		send_byte(mk("/", 1'b0, 1'b1));
		send_byte(mk(8'h5A, 1'b1, 1'b1));

		// random: mostly punctuator text with random flags, some noise
		while (bytes_sent < 425) begin
			if (bytes_sent >= 350)
				quiet = 1'b1;
			choice = $urandom_range(0, 99);
			if (choice < 70) begin
				pick = punct[$urandom_range(0, punct.size() - 1)];
				for (int i = 0; i < pick.len(); i++)
					send_byte(mk(pick[i], 1'b0, 1'($urandom_range(0, 1))));
			end else if (choice < 88) begin
				send_byte(mk(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))));
			end else begin
				send_byte(mk(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1))));
			end
		end
		byte_valid <= 1'b0;

		while (tracker.expected_tokens.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.expected_tokens.size() == 0) begin
			$display("js_punctuator_scanner_core: match");
		end else begin
			$display("js_punctuator_scanner_core: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/jps_pkg.sv
hw/rtl/jps_scan.sv
hw/rtl/jps_result_fifo.sv
hw/rtl/js_punctuator_scanner_core.sv
dv/tb_js_punctuator_scanner_core.sv
